// ===== rtl/ped_pkg.sv =====
// ----------------------------------------------------------------------------
// ped_pkg
// Shared types, constants and helpers for the percent escape decoder.
// ----------------------------------------------------------------------------
package ped_pkg;

  localparam logic [7:0] PCT_CHAR  = 8'h25;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UF     = 8'h46;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LF     = 8'h66;
  localparam logic [3:0] HEX_TEN   = 4'd10;

  localparam int unsigned BUF_DEPTH = 4;
  localparam int unsigned GEN_MAX   = 3;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'b001,
    PH_PCT   = 3'b010,
    PH_DIGIT = 3'b100
  } phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       string_end;
  } slot_t;

  function automatic logic is_hex(input logic [7:0] c);
    return ((c >= CH_0) && (c <= CH_9)) ||
           ((c >= CH_UA) && (c <= CH_UF)) ||
           ((c >= CH_LA) && (c <= CH_LF));
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] d;
    d = 8'd0;
    if ((c >= CH_0) && (c <= CH_9)) begin
      d = c - CH_0;
    end else if ((c >= CH_UA) && (c <= CH_UF)) begin
      d = c - CH_UA + {4'd0, HEX_TEN};
    end else if ((c >= CH_LA) && (c <= CH_LF)) begin
      d = c - CH_LA + {4'd0, HEX_TEN};
    end
    return d[3:0];
  endfunction

endpackage

// ===== rtl/percent_escape_decoder.sv =====
// ----------------------------------------------------------------------------
// percent_escape_decoder
// Percent decoder: '%' plus two hex digits becomes one byte, failed escapes
// pass through as literals, held bytes flush at string end.
// ----------------------------------------------------------------------------
// channel | signals                      | direction
// in      | in_valid in_stall            | request in: in_byte, final_byte
// out     | out_valid out_stall          | request out: out_byte, run_last,
//         |                              |   string_end
//
// One request is taken per cycle while the result buffer holds at most one
// byte; each request yields zero to three bytes in the same cycle.
// Results leave one byte per cycle while out_stall is low, from a four-entry
// shift buffer, so requests yielding two or three bytes raise in_stall until it drains.
// in_stall comes from registers only; it does not follow out_stall
// combinationally.
// Synchronous active-high reset empties the buffer and clears escape state.
// ----------------------------------------------------------------------------
module percent_escape_decoder (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       final_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       run_last,
  output logic       string_end
);
  import ped_pkg::*;

  phase_t      phase, phase_next;
  logic [7:0]  held_digit, held_digit_next;
  slot_t       slots      [BUF_DEPTH];
  slot_t       slots_next [BUF_DEPTH];
  logic [2:0]  cnt, cnt_next;

  logic [7:0]  gen_byte [GEN_MAX];
  logic [1:0]  gen_cnt;
  logic        push, pop, in_hex;
  logic [2:0]  base;

  assign in_stall  = (cnt > 3'd1);
  assign push      = in_valid && !in_stall;
  assign out_valid = (cnt != 3'd0);
  assign pop       = out_valid && !out_stall;
  assign out_byte   = slots[0].data;
  assign run_last   = slots[0].run_last;
  assign string_end = slots[0].string_end;
  assign in_hex    = is_hex(in_byte);
  assign base      = cnt - {2'd0, pop};

  always_comb begin
    gen_cnt         = 2'd0;
    gen_byte[0]     = 8'd0;
    gen_byte[1]     = 8'd0;
    gen_byte[2]     = 8'd0;
    phase_next      = phase;
    held_digit_next = held_digit;
    case (phase)
      PH_PCT: begin
        if (in_hex) begin
          held_digit_next = in_byte;
          phase_next      = PH_DIGIT;
        end else begin
          gen_byte[gen_cnt] = PCT_CHAR;
          gen_cnt           = gen_cnt + 2'd1;
          if (in_byte == PCT_CHAR) begin
            phase_next = PH_PCT;
          end else begin
            gen_byte[gen_cnt] = in_byte;
            gen_cnt           = gen_cnt + 2'd1;
            phase_next        = PH_IDLE;
          end
        end
      end
      PH_DIGIT: begin
        if (in_hex) begin
          gen_byte[gen_cnt] = {hex_val(held_digit), hex_val(in_byte)};
          gen_cnt           = gen_cnt + 2'd1;
          phase_next        = PH_IDLE;
        end else begin
          gen_byte[gen_cnt] = PCT_CHAR;
          gen_cnt           = gen_cnt + 2'd1;
          gen_byte[gen_cnt] = held_digit;
          gen_cnt           = gen_cnt + 2'd1;
          if (in_byte == PCT_CHAR) begin
            phase_next = PH_PCT;
          end else begin
            gen_byte[gen_cnt] = in_byte;
            gen_cnt           = gen_cnt + 2'd1;
            phase_next        = PH_IDLE;
          end
        end
      end
      default: begin
        if (in_byte == PCT_CHAR) begin
          phase_next = PH_PCT;
        end else begin
          gen_byte[gen_cnt] = in_byte;
          gen_cnt           = gen_cnt + 2'd1;
          phase_next        = PH_IDLE;
        end
      end
    endcase

    // flush held bytes at string end
    if (final_byte) begin
      if (phase_next == PH_PCT) begin
        gen_byte[gen_cnt] = PCT_CHAR;
        gen_cnt           = gen_cnt + 2'd1;
      end else if (phase_next == PH_DIGIT) begin
        gen_byte[gen_cnt] = PCT_CHAR;
        gen_cnt           = gen_cnt + 2'd1;
        gen_byte[gen_cnt] = held_digit_next;
        gen_cnt           = gen_cnt + 2'd1;
      end
      phase_next      = PH_IDLE;
      held_digit_next = 8'd0;
    end
  end

  always_comb begin
    for (int i = 0; i < BUF_DEPTH; i++) begin
      if (pop && (i < BUF_DEPTH - 1)) begin
        slots_next[i] = slots[i + 1];
      end else begin
        slots_next[i] = slots[i];
      end
      for (int k = 0; k < GEN_MAX; k++) begin
        if (push && (2'(k) < gen_cnt) && (3'(i) == base + 3'(k))) begin
          slots_next[i].data       = gen_byte[k];
          slots_next[i].run_last   = (2'(k) == gen_cnt - 2'd1);
          slots_next[i].string_end = (2'(k) == gen_cnt - 2'd1) && final_byte;
        end
      end
    end
    cnt_next = base + (push ? {1'b0, gen_cnt} : 3'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt        <= 3'd0;
      phase      <= PH_IDLE;
      held_digit <= 8'd0;
    end else begin
      cnt <= cnt_next;
      if (push) begin
        phase      <= phase_next;
        held_digit <= held_digit_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < BUF_DEPTH; i++) begin
      slots[i] <= slots_next[i];
    end
  end

endmodule

// ===== rtl/ped_checker.sv =====
// ----------------------------------------------------------------------------
// ped_checker
// Port-level checks for the percent escape decoder, bound to the top level.
// ----------------------------------------------------------------------------
module ped_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       final_byte,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       run_last,
  input logic       string_end
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_byte) &&
      $stable(run_last) && $stable(string_end))
    else $error("stalled result changed");

  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && string_end |-> run_last)
    else $error("string end without run end");

  a_final_yields: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && final_byte |=> out_valid)
    else $error("final request produced no result");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("buffer not empty after reset");

endmodule

bind percent_escape_decoder ped_checker u_ped_checker (.*);
